>>> design/srcd_pkg.sv
// srcd_pkg: shared constants, codes and types for the sparse row coordinate decoder.
// No dependencies; compiled first.
package srcd_pkg;

   // Default upper clamp for image width and height.
   localparam int unsigned MAX_DIM_DEF = 4096;

   // Configuration port.
   localparam int unsigned CSR_IDX_W  = 4;
   localparam int unsigned CSR_DATA_W = 13;

   // Field widths of the channel words.
   localparam int unsigned ROW_W = 12;
   localparam int unsigned COL_W = 12;
   localparam int unsigned VAL_W = 2;

   // Register reset values.
   localparam logic [CSR_DATA_W-1:0] WIDTH_RST  = 13'd640;
   localparam logic [CSR_DATA_W-1:0] HEIGHT_RST = 13'd480;

   // Register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 4'd0,
      CSR_IMAGE_HEIGHT = 4'd1
   } csr_idx_type;

   // Point types.
   localparam logic [VAL_W-1:0] VAL_NONE  = 2'd0;
   localparam logic [VAL_W-1:0] VAL_TYPE1 = 2'd1;
   localparam logic [VAL_W-1:0] VAL_TYPE2 = 2'd2;
   localparam logic [VAL_W-1:0] VAL_TYPE3 = 2'd3;

   // Decoder phase.
   typedef enum logic [1:0] {
      PH_FLAG   = 2'd0,
      PH_TYPE_A = 2'd1,
      PH_TYPE_B = 2'd2,
      PH_GAP    = 2'd3
   } phase_type;

   // One result word.
   typedef struct packed {
      logic [ROW_W-1:0] row_index;
      logic [COL_W-1:0] column_index;
      logic [VAL_W-1:0] point_value;
      logic             row_end;
      logic             frame_end;
      logic             decode_error;
   } rsp_word_type;

endpackage

>>> design/srcd_req_if.sv
// srcd_req_if: input channel, one code bit per word, valid/ready handshake.
// Depends on nothing.
interface srcd_req_if;
   logic valid;
   logic ready;
   logic code_bit;

   modport source (output valid, output code_bit, input ready);
   modport sink   (input valid, input code_bit, output ready);
endinterface

>>> design/srcd_rsp_if.sv
// srcd_rsp_if: result channel, one decoded point or row end per word.
// Depends on srcd_pkg for field widths.
interface srcd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [srcd_pkg::ROW_W-1:0]   row_index;
   logic [srcd_pkg::COL_W-1:0]   column_index;
   logic [srcd_pkg::VAL_W-1:0]   point_value;
   logic                         row_end;
   logic                         frame_end;
   logic                         decode_error;

   modport source (output valid, output row_index, output column_index, output point_value,
                   output row_end, output frame_end, output decode_error, input ready);
   modport sink   (input valid, input row_index, input column_index, input point_value,
                   input row_end, input frame_end, input decode_error, output ready);
endinterface

>>> design/srcd_csr_if.sv
// srcd_csr_if: configuration write channel, register index plus write data.
// Depends on srcd_pkg for widths.
interface srcd_csr_if;
   logic                              valid;
   logic                              ready;
   logic [srcd_pkg::CSR_IDX_W-1:0]    index;
   logic [srcd_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/sparse_row_coordinate_decoder.sv
// sparse_row_coordinate_decoder: serial decoder of sparse image points, row by row.
// Depends on srcd_pkg and the interfaces srcd_req_if, srcd_rsp_if, srcd_csr_if.
//
//  channel  | dir | payload                                               | accepted when
//  ---------+-----+-------------------------------------------------------+---------------
//  req_bus  | in  | code_bit                                              | valid & ready
//  rsp_bus  | out | row_index column_index point_value row_end frame_end  | valid & ready
//           |     | decode_error                                          |
//  csr_bus  | in  | index data (0 image_width, 1 image_height)            | valid & ready
//
// One code bit per cycle while the skid register is empty. Each bit updates the decoder state
// in the cycle it is taken; a word it causes is registered into the output or skid register.
// The output register plus a one-word skid register hold results; req ready
// falls only while the skid register is full, i.e. once two words wait on a stalled receiver.
// Reset (synchronous) restores 640 x 480, row 0, flag phase, both registers empty.
// csr writes are always taken and act on the next bit.
module sparse_row_coordinate_decoder #(
   parameter int unsigned MAX_DIM = srcd_pkg::MAX_DIM_DEF
) (
   input  logic            clock,
   input  logic            reset,
   srcd_req_if.sink        req_bus,
   srcd_rsp_if.source      rsp_bus,
   srcd_csr_if.sink        csr_bus
);

   // LW holds width, height and the next column; RW holds a row; BW counts gap bits.
   localparam int unsigned DIM_BITS = $clog2(MAX_DIM + 1);
   localparam int unsigned LW = (DIM_BITS > srcd_pkg::CSR_DATA_W) ? DIM_BITS
                                                                    : srcd_pkg::CSR_DATA_W;
   localparam int unsigned RW = $clog2(MAX_DIM);
   localparam int unsigned BW = $clog2(LW + 1);

   // ---------------- configuration ----------------
   logic [srcd_pkg::CSR_DATA_W-1:0] width_ff,  width_in;
   logic [srcd_pkg::CSR_DATA_W-1:0] height_ff, height_in;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            srcd_pkg::CSR_IMAGE_WIDTH:  width_in  = csr_bus.data;
            srcd_pkg::CSR_IMAGE_HEIGHT: height_in = csr_bus.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= srcd_pkg::WIDTH_RST;
         height_ff <= srcd_pkg::HEIGHT_RST;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // Effective dimensions: width clamped to [2, MAX_DIM], height to [1, MAX_DIM].
   logic [LW-1:0] w_eff, h_eff, w_raw, h_raw;
   assign w_raw = LW'(width_ff);
   assign h_raw = LW'(height_ff);
   assign w_eff = (w_raw < LW'(2)) ? LW'(2) : (w_raw > LW'(MAX_DIM)) ? LW'(MAX_DIM) : w_raw;
   assign h_eff = (h_raw < LW'(1)) ? LW'(1) : (h_raw > LW'(MAX_DIM)) ? LW'(MAX_DIM) : h_raw;

   // ---------------- decoder state ----------------
   // cnext is the previous column plus one (0 at row start).
   srcd_pkg::phase_type      phase_ff, phase_in;
   logic [LW-1:0]            cnext_ff, cnext_in;
   logic [RW-1:0]            row_ff,   row_in;
   logic [BW-1:0]            left_ff,  left_in;
   logic [LW-1:0]            acc_ff,   acc_in;
   logic [srcd_pkg::VAL_W-1:0] kind_ff, kind_in;

   logic req_fire;
   logic code;
   assign code     = req_bus.code_bit;
   assign req_fire = req_bus.valid & req_bus.ready;

   // Datapath helpers.
   logic                       kk_last, kk_over, kk_emit;
   logic [srcd_pkg::VAL_W-1:0] kk_kind;
   logic [LW-1:0]              span_m1;
   logic [BW-1:0]              gap_bits;
   logic [LW-1:0]              acc_nx;
   logic [LW:0]                ncol;
   logic                       gap_done, gap_over;
   logic [LW:0]                row_p1;
   logic                       last_row;

   assign kk_last = (cnext_ff == w_eff - LW'(1));
   assign kk_over = (cnext_ff >= w_eff);
   assign kk_emit = kk_last | kk_over;
   assign kk_kind = (phase_ff == srcd_pkg::PH_TYPE_A) ? srcd_pkg::VAL_TYPE1 :
                    code ? srcd_pkg::VAL_TYPE2 : srcd_pkg::VAL_TYPE3;
   assign span_m1 = w_eff - cnext_ff - LW'(1);

   // Gap length: bit length of span_m1, at least one.
   always_comb begin
      gap_bits = BW'(1);
      for (int i = 0; i < LW; i++) begin
         if (span_m1[i]) gap_bits = BW'(i + 1);
      end
   end

   assign acc_nx   = {acc_ff[LW-2:0], code};
   assign ncol     = {1'b0, cnext_ff} + {1'b0, acc_nx};
   assign gap_done = (left_ff == BW'(1));
   assign gap_over = (ncol >= {1'b0, w_eff});
   assign row_p1   = (LW + 1)'(row_ff) + (LW + 1)'(1);
   assign last_row = (row_p1 >= {1'b0, h_eff});

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         srcd_pkg::PH_FLAG:   phase_in = code ? srcd_pkg::PH_TYPE_A : srcd_pkg::PH_FLAG;
         srcd_pkg::PH_TYPE_A: begin
            if (!code)        phase_in = srcd_pkg::PH_TYPE_B;
            else if (kk_emit) phase_in = srcd_pkg::PH_FLAG;
            else              phase_in = srcd_pkg::PH_GAP;
         end
         srcd_pkg::PH_TYPE_B: phase_in = kk_emit ? srcd_pkg::PH_FLAG : srcd_pkg::PH_GAP;
         srcd_pkg::PH_GAP:    phase_in = gap_done ? srcd_pkg::PH_FLAG : srcd_pkg::PH_GAP;
         default:             phase_in = srcd_pkg::PH_FLAG;
      endcase
   end

   // Result word and datapath next values.
   logic                   res_valid;
   srcd_pkg::rsp_word_type res_word;
   logic                   res_rend;

   always_comb begin
      res_valid = 1'b0;
      res_rend  = 1'b0;
      res_word  = '0;
      cnext_in  = cnext_ff;
      row_in    = row_ff;
      left_in   = left_ff;
      acc_in    = acc_ff;
      kind_in   = kind_ff;
      case (phase_ff) inside
         srcd_pkg::PH_FLAG: begin
            if (!code) begin
               res_valid = 1'b1;
               res_rend  = 1'b1;
            end
         end
         srcd_pkg::PH_TYPE_A, srcd_pkg::PH_TYPE_B: begin
            if (code || phase_ff == srcd_pkg::PH_TYPE_B) begin
               kind_in = kk_kind;
               if (kk_last) begin
                  // gap omitted: point lands in the last column
                  res_valid                 = 1'b1;
                  res_rend                  = 1'b1;
                  res_word.column_index     = srcd_pkg::COL_W'(w_eff - LW'(1));
                  res_word.point_value      = kk_kind;
               end else if (kk_over) begin
                  // width shrank under the row
                  res_valid             = 1'b1;
                  res_rend              = 1'b1;
                  res_word.decode_error = 1'b1;
               end else begin
                  left_in = gap_bits;
                  acc_in  = '0;
               end
            end
         end
         default: begin
            // gap bits, MSB first
            acc_in  = acc_nx;
            left_in = left_ff - BW'(1);
            if (gap_done) begin
               res_valid = 1'b1;
               if (gap_over) begin
                  res_rend              = 1'b1;
                  res_word.decode_error = 1'b1;
               end else begin
                  cnext_in              = LW'(ncol + (LW + 1)'(1));
                  res_word.column_index = srcd_pkg::COL_W'(ncol);
                  res_word.point_value  = kind_ff;
                  res_rend              = (ncol == {1'b0, w_eff} - (LW + 1)'(1));
               end
            end
         end
      endcase
      res_word.row_index = srcd_pkg::ROW_W'(row_ff);
      res_word.row_end   = res_rend;
      if (res_rend) begin
         res_word.frame_end = last_row;
         row_in             = last_row ? '0 : RW'(row_p1);
         cnext_in           = '0;
         acc_in             = '0;
         left_in            = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= srcd_pkg::PH_FLAG;
         cnext_ff <= '0;
         row_ff   <= '0;
         left_ff  <= '0;
         acc_ff   <= '0;
         kind_ff  <= srcd_pkg::VAL_NONE;
      end else if (req_fire) begin
         phase_ff <= phase_in;
         cnext_ff <= cnext_in;
         row_ff   <= row_in;
         left_ff  <= left_in;
         acc_ff   <= acc_in;
         kind_ff  <= kind_in;
      end
   end

   // ---------------- output register and skid ----------------
   logic                   out_valid_ff, out_valid_in;
   srcd_pkg::rsp_word_type out_word_ff,  out_word_in;
   logic                   skid_valid_ff, skid_valid_in;
   srcd_pkg::rsp_word_type skid_word_ff,  skid_word_in;
   logic                   out_take, new_word;

   assign out_take = out_valid_ff & rsp_bus.ready;
   assign new_word = req_fire & res_valid;
   assign req_bus.ready = ~skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_word_in   = out_word_ff;
      skid_valid_in = skid_valid_ff;
      skid_word_in  = skid_word_ff;
      if (skid_valid_ff) begin
         // input is held off; drain skid into output when taken
         if (out_take) begin
            out_word_in   = skid_word_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || out_take) begin
         out_valid_in = new_word;
         if (new_word) out_word_in = res_word;
      end else if (new_word) begin
         skid_valid_in = 1'b1;
         skid_word_in  = res_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_word_ff  <= out_word_in;
      skid_word_ff <= skid_word_in;
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.row_index    = out_word_ff.row_index;
   assign rsp_bus.column_index = out_word_ff.column_index;
   assign rsp_bus.point_value  = out_word_ff.point_value;
   assign rsp_bus.row_end      = out_word_ff.row_end;
   assign rsp_bus.frame_end    = out_word_ff.frame_end;
   assign rsp_bus.decode_error = out_word_ff.decode_error;

   // ---------------- assertions ----------------
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register full while output register empty");

   a_gap_count_live: assert property (@(posedge clock) disable iff (reset)
      phase_ff == srcd_pkg::PH_GAP |-> left_ff != '0)
      else $error("gap phase with no bits left");

   a_frame_end_row_end: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_word_ff.frame_end |-> out_word_ff.row_end)
      else $error("frame end without row end");

   a_error_word: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_word_ff.decode_error |->
         out_word_ff.row_end && out_word_ff.point_value == srcd_pkg::VAL_NONE)
      else $error("error word malformed");

   a_row_restart: assert property (@(posedge clock) disable iff (reset)
      req_fire && res_valid && res_word.frame_end |=> row_ff == '0)
      else $error("row not restarted after frame end");

endmodule

>>> sim/sparse_row_coordinate_decoder_tb.sv
// Self-checking testbench for sparse_row_coordinate_decoder: directed table, then random bits.
// Needs srcd_pkg, the three channel interfaces and the decoder itself; nothing else.
`timescale 1ns / 1ps

module sparse_row_coordinate_decoder_tb;

   // Run limits: quiet cycles before the watchdog gives up, length of the long receiver hold.
   localparam int QUIET_LIMIT   = 3000;
   localparam int LONG_HOLD     = 300;
   localparam int PHASE_BITS    = 45;
   localparam int RANDOM_PHASES = 10;

   typedef enum { STEP_BIT, STEP_CSR } step_kind_type;

   // One row of the directed table: either a code bit or a register write.
   // A typed word, where given, replaces the predicted word for the bit it sits on.
   typedef struct {
      step_kind_type                       kind;
      logic                                code;
      srcd_pkg::csr_idx_type               idx;
      logic [srcd_pkg::CSR_DATA_W-1:0]     data;
      bit                                  typed;
      srcd_pkg::rsp_word_type              word;
   } stim_row_type;

   logic clock;
   logic reset;

   srcd_req_if req_bus ();
   srcd_rsp_if rsp_bus ();
   srcd_csr_if csr_bus ();

   sparse_row_coordinate_decoder dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Period 10 ns.
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Decoder predictor: own copy of registers and decode state
   // ------------------------------------------------------------------
   logic [srcd_pkg::CSR_DATA_W-1:0] cfg_width;
   logic [srcd_pkg::CSR_DATA_W-1:0] cfg_height;

   srcd_pkg::phase_type dec_phase;
   int          dec_col;        // previous column, -1 at row start
   int unsigned dec_row;
   int unsigned dec_gap_width;
   int unsigned dec_bits_left;
   int unsigned dec_gap_acc;
   logic [1:0]  dec_kind;

   srcd_pkg::rsp_word_type decoded_words_due[$];   // predicted words, oldest first
   int           mismatch_count;

   // Stimulus bookkeeping
   stim_row_type dir_table[$];
   bit           typed_pending;
   srcd_pkg::rsp_word_type typed_word;
   int           burst_left;
   int           gap_target;

   // Receiver pattern
   int  stall_mode;
   int  stall_left;
   int  hold_left;
   bit  long_hold_due;
   int  cyc_count;
   logic ready_next;

   int  quiet_cycles;
   bit  mon_has;
   srcd_pkg::rsp_word_type mon_word;
   srcd_pkg::rsp_word_type mon_got;
   srcd_pkg::rsp_word_type mon_exp;

   function automatic int unsigned clamp_dim(input logic [srcd_pkg::CSR_DATA_W-1:0] v,
                                             input int unsigned lo);
      if (v < lo) return lo;
      if (v > srcd_pkg::MAX_DIM_DEF) return srcd_pkg::MAX_DIM_DEF;
      return v;
   endfunction

   function automatic int unsigned bit_len(input int unsigned v);
      int unsigned n;
      n = 0;
      while (v != 0) begin
         n++;
         v >>= 1;
      end
      return n;
   endfunction

   function automatic srcd_pkg::rsp_word_type mk_word(input int unsigned row,
                                                      input int unsigned col,
                                                      input logic [1:0] val, input bit rend,
                                                      input bit fend, input bit err);
      srcd_pkg::rsp_word_type w;
      w.row_index    = row[srcd_pkg::ROW_W-1:0];
      w.column_index = col[srcd_pkg::COL_W-1:0];
      w.point_value  = val;
      w.row_end      = rend;
      w.frame_end    = fend;
      w.decode_error = err;
      return w;
   endfunction

   function automatic string fmt_word(input srcd_pkg::rsp_word_type w);
      return $sformatf("row %0d col %0d val %0d row_end %0b frame_end %0b err %0b",
                       w.row_index, w.column_index, w.point_value, w.row_end,
                       w.frame_end, w.decode_error);
   endfunction

   // Builds the output word; a row end also moves on to the next row (or wraps the frame).
   task automatic close_word(input int col, input logic [1:0] val, input bit rend,
                             input bit err, output srcd_pkg::rsp_word_type w);
      int unsigned hgt;
      bit fend;
      hgt = clamp_dim(cfg_height, 1);
      fend = 1'b0;
      w.row_index    = dec_row[srcd_pkg::ROW_W-1:0];
      w.column_index = col[srcd_pkg::COL_W-1:0];
      w.point_value  = val;
      w.row_end      = rend;
      if (rend) begin
         fend          = (dec_row + 1 >= hgt);
         dec_row       = fend ? 0 : dec_row + 1;
         dec_col       = -1;
         dec_gap_width = 0;
         dec_gap_acc   = 0;
         dec_bits_left = 0;
      end
      w.frame_end    = fend;
      w.decode_error = err;
      dec_phase      = srcd_pkg::PH_FLAG;
   endtask

   // Type code complete: either the point lands straight in the last column, the
   // column is already off the end (width shrunk), or a gap field follows.
   task automatic type_known(input logic [1:0] kind, input int last, output bit has,
                             output srcd_pkg::rsp_word_type w);
      int unsigned span;
      dec_kind = kind;
      has = 1'b0;
      w = '0;
      if (dec_col == last - 1) begin
         dec_col = last;
         close_word(last, kind, 1'b1, 1'b0, w);
         has = 1'b1;
      end else if (dec_col >= last) begin
         close_word(0, srcd_pkg::VAL_NONE, 1'b1, 1'b1, w);
         has = 1'b1;
      end else begin
         span          = last - dec_col;
         dec_gap_width = bit_len(span - 1);
         if (dec_gap_width == 0) dec_gap_width = 1;
         dec_bits_left = dec_gap_width;
         dec_gap_acc   = 0;
         dec_phase     = srcd_pkg::PH_GAP;
      end
   endtask

   task automatic decode_bit(input logic cb, output bit has, output srcd_pkg::rsp_word_type w);
      int last;
      longint ncol;
      last = int'(clamp_dim(cfg_width, 2)) - 1;
      has = 1'b0;
      w = '0;
      case (dec_phase)
         srcd_pkg::PH_FLAG: begin
            if (cb) dec_phase = srcd_pkg::PH_TYPE_A;
            else begin
               close_word(0, srcd_pkg::VAL_NONE, 1'b1, 1'b0, w);
               has = 1'b1;
            end
         end
         srcd_pkg::PH_TYPE_A: begin
            if (cb) type_known(srcd_pkg::VAL_TYPE1, last, has, w);
            else dec_phase = srcd_pkg::PH_TYPE_B;
         end
         srcd_pkg::PH_TYPE_B:
            type_known(cb ? srcd_pkg::VAL_TYPE2 : srcd_pkg::VAL_TYPE3, last, has, w);
         srcd_pkg::PH_GAP: begin
            dec_gap_acc = ((dec_gap_acc << 1) | cb) & 32'hFF_FFFF;
            if (dec_bits_left > 0) dec_bits_left--;
            if (dec_bits_left == 0) begin
               ncol = longint'(dec_col) + 1 + longint'(dec_gap_acc);
               has = 1'b1;
               if (ncol > last) close_word(0, srcd_pkg::VAL_NONE, 1'b1, 1'b1, w);
               else begin
                  dec_col = int'(ncol);
                  close_word(dec_col, dec_kind, ncol == last, 1'b0, w);
               end
            end
         end
      endcase
   endtask

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   // Bits given as a string; a typed word belongs to the last bit.
   task automatic add_bits(input string bits, input bit typed,
                           input srcd_pkg::rsp_word_type w);
      stim_row_type r;
      for (int i = 0; i < bits.len(); i++) begin
         r.kind  = STEP_BIT;
         r.code  = (bits[i] == "1");
         r.idx   = srcd_pkg::CSR_IMAGE_WIDTH;
         r.data  = '0;
         r.typed = typed && (i == bits.len() - 1);
         r.word  = w;
         dir_table.push_back(r);
      end
   endtask

   task automatic add_csr(input srcd_pkg::csr_idx_type idx,
                          input logic [srcd_pkg::CSR_DATA_W-1:0] value);
      stim_row_type r;
      r.kind  = STEP_CSR;
      r.code  = 1'b0;
      r.idx   = idx;
      r.data  = value;
      r.typed = 1'b0;
      r.word  = '0;
      dir_table.push_back(r);
   endtask

   // Mostly well-formed bits chosen from the current decode state; a few are noise.
   function automatic logic pick_code_bit();
      int span;
      if ($urandom_range(0, 99) < 6) return logic'($urandom_range(0, 1));
      case (dec_phase)
         srcd_pkg::PH_FLAG: return ($urandom_range(0, 99) < 78);
         srcd_pkg::PH_GAP: begin
            if (dec_bits_left == dec_gap_width) begin
               span = int'(clamp_dim(cfg_width, 2)) - 1 - dec_col;
               if (span < 1) span = 1;
               case ($urandom_range(0, 99) / 35)
                  0:       gap_target = 0;
                  1, 2:    gap_target = $urandom_range(0, span - 1);
                  default: gap_target = $urandom_range(0, (1 << dec_gap_width) - 1);
               endcase
               // occasionally overshoot the width on purpose
               if ($urandom_range(0, 99) < 12)
                  gap_target = $urandom_range(0, (1 << dec_gap_width) - 1);
            end
            return gap_target[dec_bits_left - 1];
         end
         default: return logic'($urandom_range(0, 1));
      endcase
   endfunction

   // Sender bursts: a random gap at the start of each burst.
   task automatic pace_sender();
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         repeat (gap) begin
            @(negedge clock);
            req_bus.valid <= 1'b0;
         end
      end
      burst_left--;
   endtask

   // Called just after a falling edge; holds the word until it is taken.
   task automatic offer_bit(input logic b, input bit typed, input srcd_pkg::rsp_word_type w);
      req_bus.valid    <= 1'b1;
      req_bus.code_bit <= b;
      typed_pending = typed;
      typed_word    = w;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Stops the sender and waits until every predicted word has come back.
   task automatic drain_idle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      burst_left = 0;
      while (decoded_words_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input srcd_pkg::csr_idx_type idx,
                            input logic [srcd_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      if (idx == srcd_pkg::CSR_IMAGE_WIDTH) cfg_width = value;
      else cfg_height = value;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%0t: %s", $time, msg);
   endtask

   // ------------------------------------------------------------------
   // Monitor: predict on each accepted code bit, check each accepted word
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            decode_bit(req_bus.code_bit, mon_has, mon_word);
            if (mon_has) decoded_words_due.push_back(typed_pending ? typed_word : mon_word);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            mon_got = {rsp_bus.row_index, rsp_bus.column_index, rsp_bus.point_value,
                       rsp_bus.row_end, rsp_bus.frame_end, rsp_bus.decode_error};
            if (decoded_words_due.size() == 0)
               note_mismatch({"unexpected word: ", fmt_word(mon_got)});
            else begin
               mon_exp = decoded_words_due.pop_front();
               if (mon_got.row_index !== mon_exp.row_index ||
                   mon_got.column_index !== mon_exp.column_index ||
                   mon_got.point_value !== mon_exp.point_value ||
                   mon_got.row_end !== mon_exp.row_end ||
                   mon_got.frame_end !== mon_exp.frame_end ||
                   mon_got.decode_error !== mon_exp.decode_error)
                  note_mismatch({"word differs, expected ", fmt_word(mon_exp),
                                 " got ", fmt_word(mon_got)});
            end
         end
      end
   end

   // Watchdog: any handshake on any channel counts as progress.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready))
         quiet_cycles = 0;
      else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // Receiver: free-running, random and periodic stretches, plus the long hold on request.
   always @(negedge clock) begin
      cyc_count++;
      if (long_hold_due && hold_left == 0) begin
         hold_left     = LONG_HOLD;
         long_hold_due = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         ready_next = 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(10, 80);
         end
         stall_left--;
         case (stall_mode)
            0:       ready_next = 1'b1;
            1:       ready_next = ($urandom_range(0, 99) < 60);
            default: ready_next = ((cyc_count % 4) == 0);
         endcase
      end
      rsp_bus.ready <= ready_next;
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      stim_row_type r;
      logic        b;
      int unsigned phase_w[RANDOM_PHASES];
      int unsigned phase_h[RANDOM_PHASES];

      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.code_bit = 1'b0;
      rsp_bus.ready    = 1'b0;
      csr_bus.valid    = 1'b0;
      csr_bus.index    = srcd_pkg::CSR_IMAGE_WIDTH;
      csr_bus.data     = '0;

      cfg_width     = srcd_pkg::WIDTH_RST;
      cfg_height    = srcd_pkg::HEIGHT_RST;
      dec_phase     = srcd_pkg::PH_FLAG;
      dec_col       = -1;
      dec_row       = 0;
      dec_gap_width = 0;
      dec_bits_left = 0;
      dec_gap_acc   = 0;
      dec_kind      = srcd_pkg::VAL_NONE;

      mismatch_count = 0;
      typed_pending  = 1'b0;
      typed_word     = '0;
      burst_left     = 0;
      gap_target     = 0;
      stall_mode     = 0;
      stall_left     = 0;
      hold_left      = 0;
      long_hold_due  = 1'b0;
      cyc_count      = 0;
      quiet_cycles   = 0;

      // Widths and heights for the random part; 0 and 8191 exercise the clamps.
      phase_w = '{5, 2, 8191, 0, 16, 4096, 3, 100, 1000, 2};
      phase_h = '{3, 1, 8191, 0, 4, 4096, 2, 6, 3, 1};

      // Directed table. Row 0 after reset: bare row end at the default size.
      add_bits("0", 1'b1, mk_word(0, 0, srcd_pkg::VAL_NONE, 1, 0, 0));
      // 2 x 1 image: every row end is also the frame end, the height drop hits row 1.
      add_csr(srcd_pkg::CSR_IMAGE_WIDTH, 13'd2);
      add_csr(srcd_pkg::CSR_IMAGE_HEIGHT, 13'd1);
      add_bits("0", 1'b1, mk_word(1, 0, srcd_pkg::VAL_NONE, 1, 1, 0));
      // After a point in column 0, each type code lands straight in the last column.
      add_bits("110", 1'b0, '0);
      add_bits("11", 1'b1, mk_word(0, 1, srcd_pkg::VAL_TYPE1, 1, 1, 0));
      add_bits("110", 1'b0, '0);
      add_bits("101", 1'b1, mk_word(0, 1, srcd_pkg::VAL_TYPE2, 1, 1, 0));
      add_bits("110", 1'b0, '0);
      add_bits("100", 1'b1, mk_word(0, 1, srcd_pkg::VAL_TYPE3, 1, 1, 0));
      // 5 x 3: three gap bits, all ones runs past the width.
      add_csr(srcd_pkg::CSR_IMAGE_WIDTH, 13'd5);
      add_csr(srcd_pkg::CSR_IMAGE_HEIGHT, 13'd3);
      add_bits("11111", 1'b1, mk_word(0, 0, srcd_pkg::VAL_NONE, 1, 0, 1));
      // Point at column 2, then the width shrinks beneath it.
      add_bits("11010", 1'b0, '0);
      add_csr(srcd_pkg::CSR_IMAGE_WIDTH, 13'd3);
      add_bits("11", 1'b1, mk_word(1, 0, srcd_pkg::VAL_NONE, 1, 0, 1));
      // Height cut below the current row: the next row end wraps the frame.
      add_csr(srcd_pkg::CSR_IMAGE_HEIGHT, 13'd2);
      add_bits("0", 1'b1, mk_word(2, 0, srcd_pkg::VAL_NONE, 1, 1, 0));

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_table[i]) begin
         r = dir_table[i];
         if (r.kind == STEP_CSR) begin
            drain_idle();
            write_reg(r.idx, r.data);
         end else begin
            pace_sender();
            @(negedge clock);
            offer_bit(r.code, r.typed, r.word);
         end
      end

      // Random part: each phase at its own image size, mid-row state carried across.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         drain_idle();
         if (p == RANDOM_PHASES - 1) begin
            phase_w[p] = $urandom_range(2, 64);
            phase_h[p] = $urandom_range(1, 8);
         end
         write_reg(srcd_pkg::CSR_IMAGE_WIDTH, phase_w[p][srcd_pkg::CSR_DATA_W-1:0]);
         write_reg(srcd_pkg::CSR_IMAGE_HEIGHT, phase_h[p][srcd_pkg::CSR_DATA_W-1:0]);
         // long receiver hold while the sender keeps pushing: fills the skid register
         if (p == 1 || p == 6) long_hold_due = 1'b1;
         repeat (PHASE_BITS) begin
            pace_sender();
            @(negedge clock);
            b = pick_code_bit();
            offer_bit(b, 1'b0, '0);
         end
      end

      drain_idle();
      repeat (10) @(posedge clock);
      if (decoded_words_due.size() != 0)
         note_mismatch($sformatf("%0d predicted words never arrived",
                                 decoded_words_due.size()));

      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
